/* rtl/ottt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ottt_pkg
// Shared types and constants of the one-time token table with throttle.
// ----------------------------------------------------------------------------
package ottt_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int SLOT_W  = 3;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_CLAIMED   = 3'd1;
    localparam logic [2:0] ST_NOMATCH   = 3'd2;
    localparam logic [2:0] ST_THROTTLED = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;

    localparam logic [1:0] ACT_PROPOSE = 2'd0;
    localparam logic [1:0] ACT_CLAIM   = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    localparam logic [1:0] REG_TTL     = 2'd0;
    localparam logic [1:0] REG_LOCKOUT = 2'd1;
    localparam logic [1:0] REG_MAXFAIL = 2'd2;

    localparam logic [15:0] TTL_RST     = 16'd600;
    localparam logic [15:0] LOCKOUT_RST = 16'd60;
    localparam logic [7:0]  MAXFAIL_RST = 8'd3;
    localparam logic [7:0]  FAIL_MAX    = 8'hFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now;
        logic [15:0] user_id;
        logic [55:0] token;
        logic        token_given;
        logic [31:0] payload_handle;
        logic [62:0] parent_ref;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]        status;
        logic [55:0]       token_out;
        logic [31:0]       payload_out;
        logic [62:0]       claimed_parent;
        logic [SLOT_W-1:0] slot_out;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] ttl_ticks;
        logic [15:0] lockout_ticks;
        logic [7:0]  max_failures;
    } t_cfg;

    typedef struct packed {
        logic [55:0] token;
        logic [15:0] user;
        logic [31:0] created;
        logic [31:0] payload;
        logic [62:0] parent;
    } t_entry;

    typedef struct packed {
        logic [15:0] user;
        logic [7:0]  count;
        logic [31:0] first;
    } t_fail;

    function automatic logic [31:0] ticks_since(input logic [31:0] now_t,
                                                input logic [31:0] then_t);
        return now_t - then_t;
    endfunction

endpackage
`default_nettype wire

/* rtl/ottt_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ottt_cfg_regs
// APB register file: expiry time, lockout window and failure limit.
// ----------------------------------------------------------------------------
module ottt_cfg_regs
    import ottt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ttl_ticks     <= TTL_RST;
            r_cfg.lockout_ticks <= LOCKOUT_RST;
            r_cfg.max_failures  <= MAXFAIL_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_TTL:     r_cfg.ttl_ticks     <= pwdata[15:0];
                REG_LOCKOUT: r_cfg.lockout_ticks <= pwdata[15:0];
                REG_MAXFAIL: r_cfg.max_failures  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TTL:     prdata = {16'd0, r_cfg.ttl_ticks};
            REG_LOCKOUT: prdata = {16'd0, r_cfg.lockout_ticks};
            REG_MAXFAIL: prdata = {24'd0, r_cfg.max_failures};
            default:     prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/one_time_token_table_with_throttle_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// one_time_token_table_with_throttle_core
// Single-use token table with expiry and a per-user claim failure throttle.
// ----------------------------------------------------------------------------
// One item is in work at a time; the next is taken as soon as the current
// result sits in the output register. A propose scans every row of the
// entry memory; a claim first scans the used rows of the failure memory,
// stopping early when the user's failure row is found, then scans every
// entry row unless the user is throttled; a clear or an unused action goes
// straight to the result. Each memory has a single read port and is
// scanned one row a cycle.
// Both memories need no clearing after reset.
module one_time_token_table_with_throttle_core
    import ottt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_beat          i_in_beat,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_beat              o_out_beat,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    typedef enum logic [1:0] {S_IDLE, S_THR, S_SCAN, S_COMMIT} t_state;

    t_cfg cfg;

    ottt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // memories
    t_entry r_ent_mem [ENTRIES];
    t_fail  r_fail_mem [ENTRIES];
    t_entry r_ent_rdata;
    t_fail  r_fail_rdata;

    // control
    t_state           r_state, n_state;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0] r_fail_used, n_fail_used;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic             r_ev, n_ev;
    logic [IDX_W-1:0] r_ev_idx, n_ev_idx;
    logic             r_out_valid, n_out_valid;

    // item context
    t_in_beat         r_req, n_req;
    t_out_beat        r_out_beat, n_out_beat;
    logic             r_throttled, n_throttled;
    logic             r_frow_found, n_frow_found;
    logic [IDX_W-1:0] r_frow_idx, n_frow_idx;
    logic [7:0]       r_frow_count, n_frow_count;
    logic [31:0]      r_frow_first, n_frow_first;
    logic             r_free_found, n_free_found;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    logic             r_old_found, n_old_found;
    logic [IDX_W-1:0] r_old_idx, n_old_idx;
    logic [31:0]      r_best, n_best;
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic [31:0]      r_hit_payload, n_hit_payload;
    logic [62:0]      r_hit_parent, n_hit_parent;

    logic             in_accept;
    logic             out_free;
    logic             commit;
    logic [CNT_W-1:0] scan_limit;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      age_e;
    logic [31:0]      age_f;
    logic             ent_expired;
    logic             ent_live;
    logic             ent_we;
    logic [IDX_W-1:0] ent_waddr;
    t_entry           ent_wdata;
    logic             fail_we;
    logic [IDX_W-1:0] fail_waddr;
    t_fail            fail_wdata;
    logic [IDX_W-1:0] slot;

    assign in_accept  = i_in_valid & ~o_in_stall;
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign commit     = (r_state == S_COMMIT) & out_free;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    assign scan_limit = (r_state == S_THR) ? r_fail_used : CNT_W'(ENTRIES);
    assign rd_en      = ((r_state == S_THR) | (r_state == S_SCAN)) & (r_issue < scan_limit);
    assign rd_addr    = r_issue[IDX_W-1:0];

    assign age_e       = ticks_since(r_req.now, r_ent_rdata.created);
    assign age_f       = ticks_since(r_req.now, r_fail_rdata.first);
    assign ent_expired = r_valid[r_ev_idx] & (age_e > {16'd0, cfg.ttl_ticks});
    assign ent_live    = r_valid[r_ev_idx] & ~ent_expired;
    assign slot        = r_free_found ? r_free_idx : r_old_idx;

    always_ff @(posedge i_clk) begin
        if (rd_en && r_state == S_SCAN) begin
            r_ent_rdata <= r_ent_mem[rd_addr];
        end
        if (ent_we) begin
            r_ent_mem[ent_waddr] <= ent_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en && r_state == S_THR) begin
            r_fail_rdata <= r_fail_mem[rd_addr];
        end
        if (fail_we) begin
            r_fail_mem[fail_waddr] <= fail_wdata;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_fail_used   = r_fail_used;
        n_issue       = r_issue;
        n_ev          = 1'b0;
        n_ev_idx      = r_ev_idx;
        n_out_valid   = r_out_valid & i_out_stall;
        n_req         = r_req;
        n_out_beat    = r_out_beat;
        n_throttled   = r_throttled;
        n_frow_found  = r_frow_found;
        n_frow_idx    = r_frow_idx;
        n_frow_count  = r_frow_count;
        n_frow_first  = r_frow_first;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_old_found   = r_old_found;
        n_old_idx     = r_old_idx;
        n_best        = r_best;
        n_hit         = r_hit;
        n_hit_idx     = r_hit_idx;
        n_hit_payload = r_hit_payload;
        n_hit_parent  = r_hit_parent;
        ent_we        = 1'b0;
        ent_waddr     = slot;
        ent_wdata     = '{token:   r_req.token,
                          user:    r_req.user_id,
                          created: r_req.now,
                          payload: r_req.payload_handle,
                          parent:  r_req.parent_ref};
        fail_we       = 1'b0;
        fail_waddr    = r_ev_idx;
        fail_wdata    = r_fail_rdata;

        if (rd_en) begin
            n_issue  = r_issue + CNT_W'(1);
            n_ev     = 1'b1;
            n_ev_idx = rd_addr;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_req        = i_in_beat;
                    n_issue      = '0;
                    n_throttled  = 1'b0;
                    n_frow_found = 1'b0;
                    n_free_found = 1'b0;
                    n_old_found  = 1'b0;
                    n_hit        = 1'b0;
                    case (i_in_beat.action)
                        ACT_PROPOSE: n_state = S_SCAN;
                        ACT_CLAIM:   n_state = S_THR;
                        default:     n_state = S_COMMIT;
                    endcase
                end
            end
            S_THR: begin
                if (r_ev && r_fail_rdata.user == r_req.user_id) begin
                    n_frow_found = 1'b1;
                    n_frow_idx   = r_ev_idx;
                    n_frow_first = r_fail_rdata.first;
                    n_issue      = '0;
                    n_ev         = 1'b0;
                    if (age_f > {16'd0, cfg.lockout_ticks}) begin
                        n_frow_count     = '0;
                        fail_we          = 1'b1;
                        fail_wdata.count = '0;
                        n_state          = S_SCAN;
                    end else begin
                        n_frow_count = r_fail_rdata.count;
                        if (r_fail_rdata.count >= cfg.max_failures) begin
                            n_throttled = 1'b1;
                            n_state     = S_COMMIT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end else if (r_issue == scan_limit) begin
                    n_issue = '0;
                    n_ev    = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_ev) begin
                    if (ent_expired) begin
                        n_valid[r_ev_idx] = 1'b0;
                    end
                    if (!ent_live && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_ev_idx;
                    end
                    if (ent_live && (!r_old_found || age_e > r_best)) begin
                        n_old_found = 1'b1;
                        n_old_idx   = r_ev_idx;
                        n_best      = age_e;
                    end
                    if (ent_live && !r_hit && r_req.token_given
                        && r_ent_rdata.user == r_req.user_id
                        && r_ent_rdata.token == r_req.token) begin
                        n_hit         = 1'b1;
                        n_hit_idx     = r_ev_idx;
                        n_hit_payload = r_ent_rdata.payload;
                        n_hit_parent  = r_ent_rdata.parent;
                    end
                end
                if (r_issue == scan_limit) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_beat  = '{status: ST_NOMATCH, token_out: '0,
                                    payload_out: '0, claimed_parent: '0,
                                    slot_out: '0};
                    n_state     = S_IDLE;
                    case (r_req.action)
                        ACT_PROPOSE: begin
                            ent_we               = 1'b1;
                            n_valid[slot]        = 1'b1;
                            n_out_beat.status    = ST_STORED;
                            n_out_beat.token_out = r_req.token;
                            n_out_beat.slot_out  = SLOT_W'(slot);
                        end
                        ACT_CLAIM: begin
                            if (r_throttled) begin
                                n_out_beat.status = ST_THROTTLED;
                            end else if (r_hit) begin
                                n_valid[r_hit_idx]        = 1'b0;
                                n_out_beat.status         = ST_CLAIMED;
                                n_out_beat.payload_out    = r_hit_payload;
                                n_out_beat.claimed_parent = r_hit_parent;
                                n_out_beat.slot_out       = SLOT_W'(r_hit_idx);
                            end else if (r_frow_found) begin
                                fail_we         = 1'b1;
                                fail_waddr      = r_frow_idx;
                                fail_wdata.user = r_req.user_id;
                                if (ticks_since(r_req.now, r_frow_first)
                                    > {16'd0, cfg.lockout_ticks}) begin
                                    fail_wdata.count = 8'd1;
                                    fail_wdata.first = r_req.now;
                                end else begin
                                    fail_wdata.count = (r_frow_count == FAIL_MAX)
                                                     ? r_frow_count
                                                     : r_frow_count + 8'd1;
                                    fail_wdata.first = r_frow_first;
                                end
                            end else if (r_fail_used < CNT_W'(ENTRIES)) begin
                                fail_we          = 1'b1;
                                fail_waddr       = r_fail_used[IDX_W-1:0];
                                fail_wdata.user  = r_req.user_id;
                                fail_wdata.count = 8'd1;
                                fail_wdata.first = r_req.now;
                                n_fail_used      = r_fail_used + CNT_W'(1);
                            end
                        end
                        ACT_CLEAR: begin
                            n_valid           = '0;
                            n_fail_used       = '0;
                            n_out_beat.status = ST_CLEARED;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_fail_used <= '0;
            r_issue     <= '0;
            r_ev        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_fail_used <= n_fail_used;
            r_issue     <= n_issue;
            r_ev        <= n_ev;
            r_out_valid <= n_out_valid;
        end
        r_ev_idx      <= n_ev_idx;
        r_req         <= n_req;
        r_out_beat    <= n_out_beat;
        r_throttled   <= n_throttled;
        r_frow_found  <= n_frow_found;
        r_frow_idx    <= n_frow_idx;
        r_frow_count  <= n_frow_count;
        r_frow_first  <= n_frow_first;
        r_free_found  <= n_free_found;
        r_free_idx    <= n_free_idx;
        r_old_found   <= n_old_found;
        r_old_idx     <= n_old_idx;
        r_best        <= n_best;
        r_hit         <= n_hit;
        r_hit_idx     <= n_hit_idx;
        r_hit_payload <= n_hit_payload;
        r_hit_parent  <= n_hit_parent;
    end

    a_fail_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fail_used <= CNT_W'(ENTRIES))
        else $error("failure row count beyond table size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled while an item is in work");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_COMMIT))
        else $error("result appeared outside commit");

    a_propose_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_req.action == ACT_PROPOSE) |=> (r_valid != '0))
        else $error("propose left the table empty");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_req.action == ACT_CLEAR) |=> (r_valid == '0 && r_fail_used == '0))
        else $error("clear left state behind");

endmodule
`default_nettype wire
